/* rtl/distance_vector_route_table_unit_macros.svh */
// Assertion macros shared by the route table modules.
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_UNIT_MACROS_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define DVRT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define DVRT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/dvrt_pkg.sv */
// Shared types and codes of the distance-vector route table.
package dvrt_pkg;

	// request classes decided at the front
	localparam logic [1:0] KIND_DELIVER = 2'd0;
	localparam logic [1:0] KIND_TEXC    = 2'd1;
	localparam logic [1:0] KIND_LOOKUP  = 2'd2;
	localparam logic [1:0] KIND_MERGE   = 2'd3;

	// result actions
	localparam logic [2:0] ACT_DELIVER   = 3'd0;
	localparam logic [2:0] ACT_FORWARD   = 3'd1;
	localparam logic [2:0] ACT_TEXC      = 3'd2;
	localparam logic [2:0] ACT_NO_ROUTE  = 3'd3;
	localparam logic [2:0] ACT_UNCHANGED = 3'd4;
	localparam logic [2:0] ACT_UPDATED   = 3'd5;
	localparam logic [2:0] ACT_ADDED     = 3'd6;
	localparam logic [2:0] ACT_FULL      = 3'd7;

	localparam logic [7:0] METRIC_MAX = 8'hFF;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  dest_id;
		logic [7:0]  metric;      // advertised metric + 1, saturated
		logic [7:0]  neighbor_id;
		logic [7:0]  ttl;         // ttl to report
		logic [31:0] now;
		logic        last;
	} dvrt_req_t;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] next_hop;
		logic [7:0] ttl_out;
		logic [7:0] route_metric;
		logic       vector_done;
	} dvrt_res_t;

	typedef struct packed {
		logic [7:0] dest;
		logic [7:0] metric;
		logic [7:0] hop;
	} dvrt_entry_t;

endpackage

/* rtl/distance_vector_route_table_unit.sv */
// Top level of the distance-vector route table: front end, back end and their queue.
//
//   channel   handshake            payload
//   -------   ------------------   -----------------------------------------------
//   config    cfg_valid/cfg_ready  cfg_data (own_id)
//   request   push/full            mode dest_id adv_metric neighbor_id ttl_in now
//                                  last_in_vector
//   result    empty/pop            action next_hop ttl_out route_metric vector_done
//
// Deliver and time-exceeded requests skip the table: their result is registered as
// soon as they leave the queue head.
// Lookup and merge requests scan the table one entry per cycle through the table
// memory's single read port, stopping at the first matching entry or, on a miss,
// after the last entry below the route count, so at most TABLE_DEPTH entries.
// Reset clears own_id, the route count and all handshake state; table contents are
// not cleared, only entries below the route count are ever read.
// The back end starts a request only while the result register is free, so a result
// waiting on pop stalls it; the two-entry request queue keeps taking requests until full.
module distance_vector_route_table_unit import dvrt_pkg::*; #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	input  logic        push,
	output logic        full,
	input  logic        mode,
	input  logic [7:0]  dest_id,
	input  logic [7:0]  adv_metric,
	input  logic [7:0]  neighbor_id,
	input  logic [7:0]  ttl_in,
	input  logic [31:0] now,
	input  logic        last_in_vector,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  action,
	output logic [7:0]  next_hop,
	output logic [7:0]  ttl_out,
	output logic [7:0]  route_metric,
	output logic        vector_done
);

	logic      q_vld;
	logic      q_pop;
	dvrt_req_t q_data;
	dvrt_res_t res;

	// classify and queue requests
	dvrt_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.push           (push),
		.full           (full),
		.mode           (mode),
		.dest_id        (dest_id),
		.adv_metric     (adv_metric),
		.neighbor_id    (neighbor_id),
		.ttl_in         (ttl_in),
		.now            (now),
		.last_in_vector (last_in_vector),
		.q_vld          (q_vld),
		.q_pop          (q_pop),
		.q_data         (q_data)
	);

	// search the table and hold the result
	dvrt_back #(
		.DEPTH (TABLE_DEPTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_vld  (q_vld),
		.q_pop  (q_pop),
		.q_data (q_data),
		.empty  (empty),
		.pop    (pop),
		.res    (res)
	);

	assign action       = res.action;
	assign next_hop     = res.next_hop;
	assign ttl_out      = res.ttl_out;
	assign route_metric = res.route_metric;
	assign vector_done  = res.vector_done;

endmodule

/* rtl/dvrt_front.sv */
// Front end: config register, request classification and a two-entry request queue.
`include "distance_vector_route_table_unit_macros.svh"
module dvrt_front import dvrt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	input  logic        push,
	output logic        full,
	input  logic        mode,
	input  logic [7:0]  dest_id,
	input  logic [7:0]  adv_metric,
	input  logic [7:0]  neighbor_id,
	input  logic [7:0]  ttl_in,
	input  logic [31:0] now,
	input  logic        last_in_vector,
	output logic        q_vld,
	input  logic        q_pop,
	output dvrt_req_t   q_data
);

	logic [7:0] own_id_q;
	dvrt_req_t  q_mem [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] q_cnt_q;
	logic       accept;
	logic [7:0] ttl_dec;
	dvrt_req_t  req;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q <= 8'd0;
		end else if (cfg_valid) begin
			own_id_q <= cfg_data;
		end
	end

	// classify
	always_comb begin
		ttl_dec         = (ttl_in == 8'd0) ? 8'd0 : ttl_in - 8'd1;
		req.dest_id     = dest_id;
		req.neighbor_id = neighbor_id;
		req.now         = now;
		req.metric      = (adv_metric == METRIC_MAX) ? METRIC_MAX : adv_metric + 8'd1;
		req.last        = mode & last_in_vector;
		if (mode) begin
			req.kind = KIND_MERGE;
			req.ttl  = 8'd0;
		end else if (dest_id == own_id_q) begin
			req.kind = KIND_DELIVER;
			req.ttl  = ttl_in;
		end else if (ttl_dec == 8'd0) begin
			req.kind = KIND_TEXC;
			req.ttl  = 8'd0;
		end else begin
			req.kind = KIND_LOOKUP;
			req.ttl  = ttl_dec;
		end
	end

	assign full   = (q_cnt_q == 2'd2);
	assign accept = push & ~full;
	assign q_vld  = (q_cnt_q != 2'd0);
	assign q_data = q_mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			q_cnt_q  <= 2'd0;
		end else begin
			if (accept) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (accept && !q_pop) begin
				q_cnt_q <= q_cnt_q + 2'd1;
			end else if (!accept && q_pop) begin
				q_cnt_q <= q_cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			q_mem[wr_ptr_q] <= req;
		end
	end

	`DVRT_ASSERT_NOW(a_q_bound, 1'b1, q_cnt_q != 2'd3, "request queue count out of range")
	`DVRT_ASSERT_NOW(a_q_pop_nonempty, q_pop, q_cnt_q != 2'd0, "pop from empty request queue")
	`DVRT_ASSERT_NEXT(a_q_grow, accept && !q_pop, q_cnt_q == $past(q_cnt_q) + 2'd1, "queue count missed a push")

endmodule

/* rtl/dvrt_back.sv */
// Back end: route table memory, linear first-match search and result register.
`include "distance_vector_route_table_unit_macros.svh"
module dvrt_back import dvrt_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_vld,
	output logic      q_pop,
	input  dvrt_req_t q_data,
	output logic      empty,
	input  logic      pop,
	output dvrt_res_t res
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic ST_IDLE   = 1'b0;
	localparam logic ST_SEARCH = 1'b1;

	logic          state_q;
	dvrt_req_t     cur_q;
	logic [CW-1:0] rd_idx_q;
	logic [IW-1:0] cmp_idx_q;
	logic          cmp_vld_q;
	logic [CW-1:0] cnt_q;
	logic          out_vld_q;
	dvrt_res_t     out_q;

	dvrt_entry_t   ent_mem [DEPTH];
	logic [31:0]   time_mem [DEPTH];
	dvrt_entry_t   rd_data_q;

	logic          start;
	logic          quick;
	logic          hit;
	logic          more;
	logic          rd_en;
	logic          fin;
	logic          is_merge;
	logic          replace;
	logic          has_room;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	logic          cnt_inc;
	dvrt_res_t     quick_res;
	dvrt_res_t     res_d;

	assign start = (state_q == ST_IDLE) && q_vld && !out_vld_q;
	assign q_pop = start;
	assign quick = start && (q_data.kind == KIND_DELIVER || q_data.kind == KIND_TEXC);

	always_comb begin
		quick_res              = '0;
		quick_res.action       = (q_data.kind == KIND_DELIVER) ? ACT_DELIVER : ACT_TEXC;
		quick_res.ttl_out      = q_data.ttl;
	end

	assign hit      = cmp_vld_q && (rd_data_q.dest == cur_q.dest_id);
	assign more     = (rd_idx_q < cnt_q);
	assign rd_en    = (state_q == ST_SEARCH) && !hit && more;
	assign fin      = (state_q == ST_SEARCH) && (hit || !more);
	assign is_merge = (cur_q.kind == KIND_MERGE);
	assign replace  = (rd_data_q.metric > cur_q.metric) || (rd_data_q.hop == cur_q.neighbor_id);
	assign has_room = (cnt_q < CW'(DEPTH));

	// resolve the request once the search ends
	always_comb begin
		res_d             = '0;
		res_d.ttl_out     = cur_q.ttl;
		res_d.vector_done = cur_q.last;
		wr_en             = 1'b0;
		wr_addr           = cmp_idx_q;
		cnt_inc           = 1'b0;
		if (hit) begin
			if (!is_merge) begin
				res_d.action       = ACT_FORWARD;
				res_d.next_hop     = rd_data_q.hop;
				res_d.route_metric = rd_data_q.metric;
			end else if (replace) begin
				res_d.action       = ACT_UPDATED;
				res_d.next_hop     = cur_q.neighbor_id;
				res_d.route_metric = cur_q.metric;
				wr_en              = fin;
			end else begin
				res_d.action       = ACT_UNCHANGED;
				res_d.next_hop     = rd_data_q.hop;
				res_d.route_metric = rd_data_q.metric;
			end
		end else if (!is_merge) begin
			res_d.action = ACT_NO_ROUTE;
		end else if (has_room) begin
			res_d.action       = ACT_ADDED;
			res_d.next_hop     = cur_q.neighbor_id;
			res_d.route_metric = cur_q.metric;
			wr_en              = fin;
			wr_addr            = cnt_q[IW-1:0];
			cnt_inc            = fin;
		end else begin
			res_d.action = ACT_FULL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_idx_q  <= '0;
			cmp_idx_q <= '0;
			cmp_vld_q <= 1'b0;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start && !quick) begin
						state_q   <= ST_SEARCH;
						rd_idx_q  <= '0;
						cmp_vld_q <= 1'b0;
					end
				end
				ST_SEARCH: begin
					cmp_vld_q <= rd_en;
					if (rd_en) begin
						rd_idx_q  <= rd_idx_q + CW'(1);
						cmp_idx_q <= rd_idx_q[IW-1:0];
					end
					if (fin) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (quick || fin) begin
				out_vld_q <= 1'b1;
			end else if (pop && out_vld_q) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cur_q <= q_data;
		end
		if (quick) begin
			out_q <= quick_res;
		end else if (fin) begin
			out_q <= res_d;
		end
	end

	// table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			ent_mem[wr_addr]  <= '{dest: cur_q.dest_id, metric: cur_q.metric,
				hop: cur_q.neighbor_id};
			time_mem[wr_addr] <= cur_q.now;
		end
		if (rd_en) begin
			rd_data_q <= ent_mem[rd_idx_q[IW-1:0]];
		end
	end

	assign empty = !out_vld_q;
	assign res   = out_q;

	`DVRT_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CW'(DEPTH), "route count exceeds table depth")
	`DVRT_ASSERT_NOW(a_fin_slot_free, fin || quick, !out_vld_q, "result overwrites a pending result")
	`DVRT_ASSERT_NEXT(a_add_counts, fin && res_d.action == ACT_ADDED, cnt_q == $past(cnt_q) + CW'(1), "added route not counted")

endmodule

/* sim/distance_vector_route_table_unit_tb.sv */
// Self-checking testbench for the distance-vector route table unit.
import dvrt_pkg::*;

typedef struct {
	bit        mode;
	bit [7:0]  dest;
	bit [7:0]  adv;
	bit [7:0]  neigh;
	bit [7:0]  ttl;
	bit [31:0] stamp;
	bit        last;
} route_req_t;

// Shadow route table plus the queue of results still owed by the block.
class route_scoreboard;
	localparam int SLOTS = 64;

	bit [7:0]    own_id;
	bit [7:0]    tbl_dest[SLOTS];
	bit [7:0]    tbl_metric[SLOTS];
	bit [7:0]    tbl_hop[SLOTS];
	bit [31:0]   tbl_stamp[SLOTS];
	int          tbl_used;
	dvrt_res_t   owed[$];
	int          errors;

	function new();
		own_id = 8'd0;
		tbl_used = 0;
		errors = 0;
	endfunction

	function void set_own_id(bit [7:0] v);
		own_id = v;
	endfunction

	// first match over the filled part, -1 when absent
	function int find_route(bit [7:0] dest);
		for (int i = 0; i < tbl_used; i++)
			if (tbl_dest[i] == dest)
				return i;
		return -1;
	endfunction

	function void note_request(route_req_t r);
		dvrt_res_t e;
		int slot;
		bit [7:0] m;
		e = '0;
		if (!r.mode) begin
			if (r.dest == own_id) begin
				e.action = ACT_DELIVER;
				e.ttl_out = r.ttl;
			end else begin
				e.ttl_out = (r.ttl == 8'd0) ? 8'd0 : r.ttl - 8'd1;
				if (e.ttl_out == 8'd0) begin
					e.action = ACT_TEXC;
				end else begin
					slot = find_route(r.dest);
					if (slot >= 0) begin
						e.action = ACT_FORWARD;
						e.next_hop = tbl_hop[slot];
						e.route_metric = tbl_metric[slot];
					end else begin
						e.action = ACT_NO_ROUTE;
					end
				end
			end
		end else begin
			m = (r.adv == METRIC_MAX) ? METRIC_MAX : r.adv + 8'd1;
			e.vector_done = r.last;
			slot = find_route(r.dest);
			if (slot >= 0) begin
				// better metric, or news from the current next hop, rewrites the entry
				if (tbl_metric[slot] > m || tbl_hop[slot] == r.neigh) begin
					tbl_metric[slot] = m;
					tbl_hop[slot] = r.neigh;
					tbl_stamp[slot] = r.stamp;
					e.action = ACT_UPDATED;
				end else begin
					e.action = ACT_UNCHANGED;
				end
				e.next_hop = tbl_hop[slot];
				e.route_metric = tbl_metric[slot];
			end else if (tbl_used < SLOTS) begin
				tbl_dest[tbl_used] = r.dest;
				tbl_metric[tbl_used] = m;
				tbl_hop[tbl_used] = r.neigh;
				tbl_stamp[tbl_used] = r.stamp;
				tbl_used++;
				e.action = ACT_ADDED;
				e.next_hop = r.neigh;
				e.route_metric = m;
			end else begin
				e.action = ACT_FULL;
			end
		end
		owed.push_back(e);
	endfunction

	function void check_result(dvrt_res_t got);
		dvrt_res_t e;
		if (owed.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected result: action %0d hop %0d ttl %0d metric %0d done %0d",
					got.action, got.next_hop, got.ttl_out, got.route_metric,
					got.vector_done);
			return;
		end
		e = owed.pop_front();
		if (got.action !== e.action || got.next_hop !== e.next_hop ||
				got.ttl_out !== e.ttl_out || got.route_metric !== e.route_metric ||
				got.vector_done !== e.vector_done) begin
			errors++;
			if (errors <= 10)
				$display("mismatch: exp action %0d hop %0d ttl %0d metric %0d done %0d",
					e.action, e.next_hop, e.ttl_out, e.route_metric, e.vector_done,
					" / got action %0d hop %0d ttl %0d metric %0d done %0d",
					got.action, got.next_hop, got.ttl_out, got.route_metric,
					got.vector_done);
		end
	endfunction
endclass

module distance_vector_route_table_unit_tb;

	// consecutive cycles without any handshake before the run is declared hung;
	// a correct run needs at most a full-table scan plus the longest gap and stall
	localparam int HANG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 80;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;
	logic        push;
	logic        full;
	logic        mode;
	logic [7:0]  dest_id;
	logic [7:0]  adv_metric;
	logic [7:0]  neighbor_id;
	logic [7:0]  ttl_in;
	logic [31:0] now;
	logic        last_in_vector;
	logic        empty;
	logic        pop;
	logic [2:0]  action;
	logic [7:0]  next_hop;
	logic [7:0]  ttl_out;
	logic [7:0]  route_metric;
	logic        vector_done;

	route_scoreboard oracle;
	bit [7:0]        own_now;
	bit              steady;     // when set, neither side inserts gaps
	int              hang_count;

	distance_vector_route_table_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.mode(mode),
		.dest_id(dest_id),
		.adv_metric(adv_metric),
		.neighbor_id(neighbor_id),
		.ttl_in(ttl_in),
		.now(now),
		.last_in_vector(last_in_vector),
		.empty(empty),
		.pop(pop),
		.action(action),
		.next_hop(next_hop),
		.ttl_out(ttl_out),
		.route_metric(route_metric),
		.vector_done(vector_done)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic route_req_t mk_req(bit md, bit [7:0] dst, bit [7:0] adv,
			bit [7:0] nb, bit [7:0] ttl, bit [31:0] stamp, bit last);
		route_req_t r;
		r.mode = md;
		r.dest = dst;
		r.adv = adv;
		r.neigh = nb;
		r.ttl = ttl;
		r.stamp = stamp;
		r.last = last;
		return r;
	endfunction

	// data packet: own id, known destinations, or anything; TTL biased to edges
	function automatic route_req_t packet_req(int dest_hi);
		route_req_t r;
		int pick;
		r = mk_req(1'b0, 8'($urandom_range(0, dest_hi)), 8'($urandom), 8'($urandom),
			8'($urandom), $urandom, 1'($urandom));
		pick = $urandom_range(0, 99);
		if (pick < 15)
			r.dest = own_now;
		else if (pick < 40)
			r.dest = 8'($urandom);
		case ($urandom_range(0, 9))
			0: r.ttl = 8'd0;
			1: r.ttl = 8'd1;
			2: r.ttl = 8'd2;
			3: r.ttl = 8'hFF;
			default: ;
		endcase
		return r;
	endfunction

	// one vector entry from peer; a few are noise (odd neighbor, misplaced end mark)
	function automatic route_req_t vector_req(int dest_hi, bit [7:0] peer, bit tail);
		route_req_t r;
		r = mk_req(1'b1, 8'($urandom_range(0, dest_hi)), 8'($urandom), peer,
			8'($urandom), $urandom, tail ^ ($urandom_range(0, 9) == 0));
		if ($urandom_range(0, 19) == 0)
			r.dest = own_now;
		case ($urandom_range(0, 9))
			0, 1, 2: r.adv = 8'($urandom_range(0, 4));
			3: r.adv = 8'($urandom_range(254, 255));
			default: ;
		endcase
		if ($urandom_range(0, 9) == 0)
			r.neigh = 8'($urandom);
		return r;
	endfunction

	// push/full side; push stays high across back-to-back requests
	task automatic send_req(input route_req_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		mode <= r.mode;
		dest_id <= r.dest;
		adv_metric <= r.adv;
		neighbor_id <= r.neigh;
		ttl_in <= r.ttl;
		now <= r.stamp;
		last_in_vector <= r.last;
		do @(posedge clk); while (full);
		oracle.note_request(r);
	endtask

	// stop pushing, then wait until every owed result has been checked
	task automatic wait_drained();
		push <= 1'b0;
		while (oracle.owed.size() != 0)
			@(posedge clk);
	endtask

	// caller makes sure the block is idle first
	task automatic write_own_id(input bit [7:0] v);
		push <= 1'b0;
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		own_now = v;
		oracle.set_own_id(v);
	endtask

	// random traffic: vector bursts from one neighbor, packet bursts in between
	task automatic run_random(input int goal, input int dest_hi);
		int sent;
		int burst;
		bit [7:0] peer;
		sent = 0;
		while (sent < goal) begin
			steady = ($urandom_range(0, 9) == 0);
			if ($urandom_range(0, 99) == 0)
				wait_drained();
			burst = $urandom_range(1, 8);
			if ($urandom_range(0, 9) < 5) begin
				peer = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
				for (int i = 0; i < burst; i++)
					send_req(vector_req(dest_hi, peer, i == burst - 1));
			end else begin
				for (int i = 0; i < burst; i++)
					send_req(packet_req(dest_hi));
			end
			sent += burst;
		end
		steady = 1'b0;
	endtask

	// result side: pop with random stalls, check each accepted result
	initial begin
		int hold;
		pop = 1'b0;
		hold = 0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty)
				oracle.check_result('{action: action, next_hop: next_hop, ttl_out: ttl_out,
					route_metric: route_metric, vector_done: vector_done});
			if (!arst_n) begin
				pop <= 1'b0;
			end else if (hold > 0) begin
				hold--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
				hold = pick_gap();
			end
		end
	end

	// hang detector: any handshake on any channel restarts the count
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				hang_count <= 0;
			else
				hang_count <= hang_count + 1;
			if (hang_count >= HANG_LIMIT) begin
				$display("distance_vector_route_table_unit_tb NOT OK");
				$finish;
			end
		end
	end

	initial begin
		oracle = new();
		hang_count = 0;
		steady = 1'b0;
		own_now = 8'd0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 8'd0;
		push = 1'b0;
		mode = 1'b0;
		dest_id = 8'd0;
		adv_metric = 8'd0;
		neighbor_id = 8'd0;
		ttl_in = 8'd0;
		now = 32'd0;
		last_in_vector = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part with own id 0x2A
		write_own_id(8'h2A);
		send_req(mk_req(1'b0, 8'd5, 8'd0, 8'd0, 8'd10, 32'd0, 1'b0));    // empty table: no route
		send_req(mk_req(1'b0, 8'h2A, 8'd0, 8'd0, 8'd0, 32'd0, 1'b0));    // local, TTL 0 kept
		send_req(mk_req(1'b0, 8'h2A, 8'd0, 8'd0, 8'hFF, 32'd0, 1'b0));   // local, TTL kept
		send_req(mk_req(1'b0, 8'd5, 8'd0, 8'd0, 8'd0, 32'd0, 1'b0));     // TTL 0: no wrap
		send_req(mk_req(1'b0, 8'd5, 8'd0, 8'd0, 8'd1, 32'd0, 1'b0));     // TTL 1 expires
		send_req(mk_req(1'b1, 8'd5, 8'hFF, 8'd7, 8'd0, 32'd1, 1'b0));    // add, metric saturates
		send_req(mk_req(1'b1, 8'd5, 8'd3, 8'd9, 8'd0, 32'd2, 1'b0));     // better metric
		send_req(mk_req(1'b1, 8'd5, 8'd200, 8'd7, 8'd0, 32'd3, 1'b0));   // worse, other hop
		send_req(mk_req(1'b1, 8'd5, 8'd200, 8'd9, 8'd0, 32'd4, 1'b0));   // worse, same hop
		send_req(mk_req(1'b1, 8'd5, 8'd200, 8'd9, 8'd0, 32'd5, 1'b1));   // same hop, same metric: still updated
		send_req(mk_req(1'b0, 8'd5, 8'd0, 8'd0, 8'd2, 32'd0, 1'b0));     // forward
		send_req(mk_req(1'b1, 8'h2A, 8'd0, 8'hFF, 8'd0, 32'd6, 1'b0));   // own id as vector dest
		send_req(mk_req(1'b0, 8'h2A, 8'd0, 8'd0, 8'd1, 32'd0, 1'b0));    // still delivered
		send_req(mk_req(1'b1, 8'd0, 8'd254, 8'd0, 8'd0, 32'hFFFF_FFFF, 1'b1));
		send_req(mk_req(1'b1, 8'hFF, 8'd0, 8'd0, 8'hFF, 32'd0, 1'b1));
		send_req(mk_req(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b1));
		send_req(mk_req(1'b0, 8'd0, 8'd0, 8'd0, 8'd3, 32'd0, 1'b0));

		// small destination range: many updates, table stays below capacity
		wait_drained();
		write_own_id(8'hFF);
		run_random(480, 39);

		// wider range fills the table; later adds report it full
		wait_drained();
		write_own_id(8'($urandom));
		run_random(480, 99);

		wait_drained();
		write_own_id(8'h00);
		run_random(470, 255);
		push <= 1'b0;

		// let any stray result show up before judging
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (oracle.errors == 0 && oracle.owed.size() == 0)
			$display("distance_vector_route_table_unit_tb OK");
		else
			$display("distance_vector_route_table_unit_tb NOT OK");
		$finish;
	end

endmodule
